/* rtl/tps_pkg.sv */
// Shared types, constants and helper functions for the track point statistics block.
`timescale 1ns / 1ps

package tps_pkg;

  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned ALT_W      = 16;
  localparam int unsigned PEAK_W     = 15;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned SECOND_W   = 6;
  localparam int unsigned TSEC_W     = 17;
  localparam int unsigned DELTA_W    = TSEC_W + 1;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 136;

  localparam logic signed [DELTA_W-1:0] SECONDS_PER_DAY = DELTA_W'(24 * 60 * 60);
  localparam logic [TSEC_W-1:0] SECONDS_PER_HOUR = TSEC_W'(3600);
  localparam logic [TSEC_W-1:0] SECONDS_PER_MINUTE = TSEC_W'(60);

  typedef struct packed {
    logic                       track_start;
    logic [SPEED_W-1:0]         speed;
    logic signed [ALT_W-1:0]    altitude;
    logic [HOUR_W-1:0]          hour;
    logic [MINUTE_W-1:0]        minute;
    logic [SECOND_W-1:0]        second;
  } point_t;

  typedef struct packed {
    logic [SPEED_W-1:0]         speed_top;
    logic [PEAK_W-1:0]          altitude_top;
    logic signed [ALT_W-1:0]    altitude_bottom;
    logic [SUM_W-1:0]           climb_total;
    logic [SUM_W-1:0]           descent_total;
    logic [SUM_W-1:0]           zero_speed_seconds;
  } result_t;

  // Time of day in seconds from the raw fields.
  function automatic logic [TSEC_W-1:0] time_seconds(input logic [HOUR_W-1:0] hr,
                                                      input logic [MINUTE_W-1:0] mn,
                                                      input logic [SECOND_W-1:0] sc);
    return TSEC_W'(TSEC_W'(hr) * SECONDS_PER_HOUR)
         + TSEC_W'(TSEC_W'(mn) * SECONDS_PER_MINUTE)
         + TSEC_W'(sc);
  endfunction

  // Add and clamp at all ones.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

/* rtl/tps_core.sv */
// Running statistics state and its per-point update logic.
`timescale 1ns / 1ps

module tps_core
  import tps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  point_t  pt,
  output result_t result
);

  logic                    has_previous;
  logic                    nonzero_seen;
  logic signed [ALT_W-1:0] previous_altitude;
  logic [TSEC_W-1:0]       previous_time_seconds;
  logic [SPEED_W-1:0]      speed_peak;
  logic [PEAK_W-1:0]       altitude_peak;
  logic signed [ALT_W-1:0] altitude_floor;
  logic [SUM_W-1:0]        climb_sum;
  logic [SUM_W-1:0]        descent_sum;
  logic [SUM_W-1:0]        idle_seconds;

  logic                    alt_nz;
  logic                    restart;
  logic                    has_prev_e;
  logic                    nonzero_seen_next;
  logic [TSEC_W-1:0]       tsec;
  logic signed [DELTA_W-1:0] dt_raw;
  logic signed [DELTA_W-1:0] dt_wrap;
  logic [TSEC_W-1:0]       dt;
  logic signed [ALT_W:0]   alt_diff;
  logic [ALT_W-1:0]        rise;
  logic [ALT_W-1:0]        drop;
  logic [SPEED_W-1:0]      speed_peak_b;
  logic [PEAK_W-1:0]       altitude_peak_b;
  logic [SUM_W-1:0]        climb_b;
  logic [SUM_W-1:0]        descent_b;
  logic [SUM_W-1:0]        idle_b;
  logic [SPEED_W-1:0]      speed_peak_next;
  logic [PEAK_W-1:0]       altitude_peak_next;
  logic signed [ALT_W-1:0] altitude_floor_next;
  logic [SUM_W-1:0]        climb_sum_next;
  logic [SUM_W-1:0]        descent_sum_next;
  logic [SUM_W-1:0]        idle_seconds_next;

  always_comb begin
    alt_nz  = (pt.altitude != '0);
    // A new track or the first known altitude clears everything
    restart = pt.track_start || (alt_nz && !nonzero_seen);
    nonzero_seen_next = pt.track_start ? alt_nz : (nonzero_seen || alt_nz);
    has_prev_e = restart ? 1'b0 : has_previous;

    speed_peak_b    = restart ? '0 : speed_peak;
    altitude_peak_b = restart ? '0 : altitude_peak;
    climb_b         = restart ? '0 : climb_sum;
    descent_b       = restart ? '0 : descent_sum;
    idle_b          = restart ? '0 : idle_seconds;

    tsec    = time_seconds(pt.hour, pt.minute, pt.second);
    dt_raw  = $signed({1'b0, tsec}) - $signed({1'b0, previous_time_seconds});
    dt_wrap = (dt_raw < 0) ? dt_raw + SECONDS_PER_DAY : dt_raw;
    dt      = (dt_wrap < 0) ? '0 : dt_wrap[TSEC_W-1:0];

    alt_diff = ALT_W'(0) + ({pt.altitude[ALT_W-1], pt.altitude}
             - {previous_altitude[ALT_W-1], previous_altitude});
    rise = alt_diff[ALT_W-1:0];
    drop = ALT_W'(-alt_diff);

    speed_peak_next = (pt.speed > speed_peak_b) ? pt.speed : speed_peak_b;
    altitude_peak_next = (pt.altitude > $signed({1'b0, altitude_peak_b}))
                       ? pt.altitude[PEAK_W-1:0] : altitude_peak_b;
    altitude_floor_next = (!has_prev_e || pt.altitude < altitude_floor)
                        ? pt.altitude : altitude_floor;

    climb_sum_next    = climb_b;
    descent_sum_next  = descent_b;
    idle_seconds_next = idle_b;
    if (has_prev_e) begin
      if (pt.speed == '0) begin
        idle_seconds_next = sat_add(idle_b, SUM_W'(dt));
      end
      if (previous_altitude != '0 && alt_nz) begin
        if (previous_altitude < pt.altitude) begin
          climb_sum_next = sat_add(climb_b, SUM_W'(rise));
        end else begin
          descent_sum_next = sat_add(descent_b, SUM_W'(drop));
        end
      end
    end

    result.speed_top          = speed_peak_next;
    result.altitude_top       = altitude_peak_next;
    result.altitude_bottom    = altitude_floor_next;
    result.climb_total        = climb_sum_next;
    result.descent_total      = descent_sum_next;
    result.zero_speed_seconds = idle_seconds_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_previous          <= 1'b0;
      nonzero_seen          <= 1'b0;
      previous_altitude     <= '0;
      previous_time_seconds <= '0;
      speed_peak            <= '0;
      altitude_peak         <= '0;
      altitude_floor        <= '0;
      climb_sum             <= '0;
      descent_sum           <= '0;
      idle_seconds          <= '0;
    end else if (en) begin
      has_previous          <= 1'b1;
      nonzero_seen          <= nonzero_seen_next;
      previous_altitude     <= pt.altitude;
      previous_time_seconds <= tsec;
      speed_peak            <= speed_peak_next;
      altitude_peak         <= altitude_peak_next;
      altitude_floor        <= altitude_floor_next;
      climb_sum             <= climb_sum_next;
      descent_sum           <= descent_sum_next;
      idle_seconds          <= idle_seconds_next;
    end
  end

endmodule

/* rtl/track_point_statistics.sv */
// Top level of the track point statistics block: stream ports and item registers.
`timescale 1ns / 1ps

// Track point statistics. Each accepted track point yields exactly one result item
// carrying the running maximum speed, maximum altitude (from zero), minimum
// altitude, total climb, total descent and seconds spent at zero speed. Set
// s_tuser to start a new track. Zero-altitude points at the head of a track are
// counted until the first nonzero altitude, which restarts all statistics. The
// block takes one item per clock unless stalled: an input register feeds one
// level of compare/add logic that updates the statistics and loads the result
// register; a point passes the input register, then the result register, before
// m_tvalid rises. The input side accepts while its register is empty or its point
// moves on in the same cycle; m_tready low with a result waiting stalls both registers once the input one is full.

module track_point_statistics
  import tps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // speed[7:0], altitude[23:8], hour[28:24], minute[34:29], second[40:35], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // track_start[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // speed_top[7:0], altitude_top[22:8], altitude_bottom[38:23], climb_total[70:39],
  // descent_total[102:71], zero_speed_seconds[134:103], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  point_t  in_pt;
  logic    in_valid;
  result_t core_result;
  result_t res;
  logic    out_valid;
  logic    advance;

  // Move the held point into the result register when that register is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Capture the payload; no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pt.track_start <= s_tuser;
      in_pt.speed       <= s_tdata[7:0];
      in_pt.altitude    <= s_tdata[23:8];
      in_pt.hour        <= s_tdata[28:24];
      in_pt.minute      <= s_tdata[34:29];
      in_pt.second      <= s_tdata[40:35];
    end
  end

  // Update the statistics once per point, as it advances
  tps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .pt     (in_pt),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, res.zero_speed_seconds, res.descent_total, res.climb_total,
                     res.altitude_bottom, res.altitude_top, res.speed_top};

endmodule
